@@ hw/rtl/ptq_pkg.sv @@
// ---------------------------------------------------------------------------
// ptq_pkg: shared types, constants and helpers for the pid trapezoid unit
// Holds register indexes, 32-bit limits and the saturate / clamp helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic signed [33:0] wide_type;

   // configuration register indexes
   localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd3;
   localparam logic [2:0] REG_OUT_UPPER     = 3'd4;
   localparam logic [2:0] REG_OUT_LOWER     = 3'd5;
   localparam logic [2:0] REG_INTEG_UPPER   = 3'd6;
   localparam logic [2:0] REG_INTEG_LOWER   = 3'd7;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // saturate a 34-bit signed value to 32 bits
   function automatic word_type sat34(input wide_type v);
      word_type r;
      if (v > 34'sh0_7FFF_FFFF) r = WORD_MAX;
      else if (v < -34'sh0_8000_0000) r = WORD_MIN;
      else r = v[31:0];
      return r;
   endfunction

   // with inverted limits, values above the upper limit get it, all others the lower
   function automatic word_type clamp32(input word_type v, input word_type hi,
                                        input word_type lo);
      word_type r;
      if (v > hi) r = hi;
      else if (v < lo) r = lo;
      else r = v;
      return r;
   endfunction

   // halve, truncating toward zero
   function automatic word_type half_trunc(input word_type x);
      logic signed [32:0] t;
      t = {x[31], x} + {32'd0, x[31]};
      t = t >>> 1;
      return t[31:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ptq_mul.sv @@
// ---------------------------------------------------------------------------
// ptq_mul: shared fixed-point multiplier
// Registers the full 64-bit product, then floors by the fraction bits and
// saturates to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_mul
   import ptq_pkg::*;
#(
   parameter int FRAC_BITS = 13
) (
   input  wire logic     clock,
   input  wire word_type op_a,
   input  wire word_type op_b,
   input  wire logic     go,
   output word_type      prod_q
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [63:0] shifted;

   // product register, loads on issue
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (go) begin
         prod_ff <= prod_in;
      end
   end

   // floor shift and saturate
   always_comb begin
      shifted = prod_ff >>> FRAC_BITS;
      if (shifted > 64'sh0000_0000_7FFF_FFFF) prod_q = WORD_MAX;
      else if (shifted < -64'sh0000_0000_8000_0000) prod_q = WORD_MIN;
      else prod_q = shifted[31:0];
   end

endmodule

`default_nettype wire

@@ hw/rtl/ptq_div.sv @@
// ---------------------------------------------------------------------------
// ptq_div: serial fixed-point divider
// Restoring division of (num << FRAC_BITS) by an unsigned period, one
// quotient bit per cycle, truncated toward zero and saturated to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_div
   import ptq_pkg::*;
#(
   parameter int FRAC_BITS = 13
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire word_type    num,
   input  wire logic [30:0] den,
   output logic             done,
   output word_type         quot
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] dvd_ff, dvd_in;
   logic [30:0]   rem_ff, rem_in;
   logic [30:0]   den_ff;
   logic          neg_ff, zero_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [31:0]   rem2;
   logic          ge;
   logic [32:0]   mag;

   // one restoring step
   always_comb begin
      rem2 = {rem_ff, dvd_ff[NW-1]};
      ge   = (rem2 >= {1'b0, den_ff});
      mag  = num[31] ? (33'd0 - {num[31], num}) : {num[31], num};
   end

   // sequencing of the iterations
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = {mag[31:0], {FRAC_BITS{1'b0}}};
         rem_in = '0;
         cnt_in = CW'(NW - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? 31'(rem2 - {1'b0, den_ff}) : rem2[30:0];
         dvd_in = {dvd_ff[NW-2:0], ge};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff  <= den;
         neg_ff  <= num[31];
         zero_ff <= (num == '0);
      end
   end

   // sign and saturation of the quotient
   always_comb begin
      if (zero_ff) quot = '0;
      else if (!neg_ff) begin
         if (dvd_ff > NW'(32'h7FFF_FFFF)) quot = WORD_MAX;
         else quot = dvd_ff[31:0];
      end else begin
         if (dvd_ff > NW'(33'h0_8000_0000)) quot = WORD_MIN;
         else quot = 32'd0 - dvd_ff[31:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ptq_wrap.sv @@
// ---------------------------------------------------------------------------
// ptq_wrap: serial angle wrap
// Reduces a difference into [-180, 180) degrees: the whole-degree part is
// taken modulo 360 by one compare and subtract per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_wrap
   import ptq_pkg::*;
#(
   parameter int FRAC_BITS = 13
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [32:0] diff,
   output logic                    done,
   output word_type                err
);

   localparam int KS = 25 - FRAC_BITS;
   localparam int RW = 36 - FRAC_BITS;
   localparam int CW = $clog2(KS + 2);
   localparam logic signed [33:0] HALF_TURN = 34'sd180 <<< FRAC_BITS;
   localparam logic [RW-1:0] TURN_TOP = RW'(360) << KS;

   logic signed [33:0]   v;
   logic signed [33:0]   q;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [RW-1:0]        sub_ff, sub_in;
   logic [FRAC_BITS-1:0] low_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [33:0]          m;

   // offset by a half turn and floor to whole degrees
   always_comb begin
      v = {diff[32], diff} + HALF_TURN;
      q = v >>> FRAC_BITS;
   end

   always_comb begin
      rem_in  = rem_ff;
      sub_in  = sub_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = q[RW-1:0] + TURN_TOP;
         sub_in = TURN_TOP;
         cnt_in = CW'(KS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= sub_ff) rem_in = rem_ff - sub_ff;
         sub_in = sub_ff >> 1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sub_ff <= sub_in;
      cnt_ff <= cnt_in;
      if (start) low_ff <= v[FRAC_BITS-1:0];
   end

   // reassemble and recenter
   always_comb begin
      m   = 34'({rem_ff[8:0], low_ff});
      err = sat34(wide_type'(m) - HALF_TURN);
   end

   assign done = done_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pid_trapezoid_q13_unit.sv @@
// ---------------------------------------------------------------------------
// pid_trapezoid_q13_unit: fixed-point PID controller, trapezoidal integral
// Drives one control output per feedback / setpoint sample.
// ---------------------------------------------------------------------------
// Usage:
//   Request beat (req_*): feedback, target, clear_history. Taken when
//   req_valid is high and req_stall is low. req_stall stays high from the
//   accepted beat until its response beat has been taken.
//   Response beat (rsp_*): drive, held while rsp_stall is high.
//   Csr port: csr_index / csr_data written when csr_valid and csr_ready;
//   csr_ready is always high. Write only while the unit is idle.
// Sequence (accept to rsp_valid):
//   clear beat: answered in the cycle after it is taken; first linear
//   sample: ST_FIRST, ST_FDONE; normal sample: ST_MSUM, ST_INTEG, ST_MKI,
//   ST_ADD1, ST_DIVW (waits for the serial divider that forms the
//   derivative, one quotient bit per cycle), ST_MKD, ST_FIN; angle mode
//   first waits in ST_WRAP for the serial modulo-360. One sample in flight;
//   the next beat is taken the cycle after the response beat leaves.
// Reset: gains 0, period 8, limits wide open, history cleared, and the
//   next sample is treated as the first one.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_trapezoid_q13_unit
   import ptq_pkg::*;
#(
   parameter int ANGLE_WRAP = 0,
   parameter int FRAC_BITS  = 13
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire word_type    req_feedback,
   input  wire word_type    req_target,
   input  wire logic        req_clear_history,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output word_type         rsp_drive,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRAP  = 4'd1;
   localparam logic [3:0] ST_FIRST = 4'd2;
   localparam logic [3:0] ST_FDONE = 4'd3;
   localparam logic [3:0] ST_MSUM  = 4'd4;
   localparam logic [3:0] ST_INTEG = 4'd5;
   localparam logic [3:0] ST_MKI   = 4'd6;
   localparam logic [3:0] ST_ADD1  = 4'd7;
   localparam logic [3:0] ST_DIVW  = 4'd8;
   localparam logic [3:0] ST_MKD   = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   // configuration registers
   word_type    kp_ff, ki_ff, kd_ff;
   logic [30:0] period_ff;
   word_type    out_hi_ff, out_lo_ff, int_hi_ff, int_lo_ff;

   // controller state and work registers
   logic [3:0] state_ff, state_in;
   word_type   prev_ff, prev_in;
   word_type   acc_ff, acc_in;
   logic       started_ff, started_in;
   word_type   err_ff, err_in;
   word_type   integ_ff, integ_in;
   wide_type   total_ff, total_in;
   word_type   drive_ff, drive_in;

   logic               accept;
   logic signed [32:0] diff;
   word_type           mul_a, mul_b, mul_q;
   logic               mul_go;
   logic               div_start, div_done;
   word_type           div_q;
   logic               wrap_start, wrap_done;
   word_type           wrap_err;
   word_type           sum_e, diff_e;
   wide_type           total_fin;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_drive = drive_ff;
   assign csr_ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
         period_ff <= 31'd8;
         out_hi_ff <= WORD_MAX;
         out_lo_ff <= WORD_MIN;
         int_hi_ff <= WORD_MAX;
         int_lo_ff <= WORD_MIN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PROP_GAIN:     kp_ff     <= csr_data;
            REG_INTEG_GAIN:    ki_ff     <= csr_data;
            REG_DERIV_GAIN:    kd_ff     <= csr_data;
            REG_SAMPLE_PERIOD: period_ff <= csr_data[30:0];
            REG_OUT_UPPER:     out_hi_ff <= csr_data;
            REG_OUT_LOWER:     out_lo_ff <= csr_data;
            REG_INTEG_UPPER:   int_hi_ff <= csr_data;
            REG_INTEG_LOWER:   int_lo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // error terms
   always_comb begin
      diff      = {req_target[31], req_target} - {req_feedback[31], req_feedback};
      sum_e     = sat34(wide_type'(err_ff) + wide_type'(prev_ff));
      diff_e    = sat34(wide_type'(err_ff) - wide_type'(prev_ff));
      total_fin = total_ff + wide_type'(mul_q);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_go = 1'b1;
      case (state_ff)
         ST_FIRST: begin
            mul_a = kp_ff;
            mul_b = err_ff;
         end
         ST_MSUM: begin
            mul_a = sum_e;
            mul_b = {1'b0, period_ff};
         end
         ST_INTEG: begin
            mul_a = kp_ff;
            mul_b = err_ff;
         end
         ST_MKI: begin
            mul_a = ki_ff;
            mul_b = integ_ff;
         end
         ST_MKD: begin
            mul_a = kd_ff;
            mul_b = div_q;
         end
         default: mul_go = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      prev_in    = prev_ff;
      acc_in     = acc_ff;
      started_in = started_ff;
      err_in     = err_ff;
      integ_in   = integ_ff;
      total_in   = total_ff;
      drive_in   = drive_ff;
      div_start  = 1'b0;
      wrap_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in = sat34(wide_type'(diff));
               if (req_clear_history) begin
                  prev_in  = '0;
                  acc_in   = '0;
                  drive_in = '0;
                  state_in = ST_OUT;
               end else if (ANGLE_WRAP != 0) begin
                  wrap_start = 1'b1;
                  state_in   = ST_WRAP;
               end else if (!started_ff) begin
                  state_in = ST_FIRST;
               end else begin
                  state_in = ST_MSUM;
               end
            end
         end
         ST_WRAP: begin
            if (wrap_done) begin
               err_in = wrap_err;
               if (!started_ff) begin
                  prev_in    = wrap_err;
                  acc_in     = '0;
                  started_in = 1'b1;
               end
               state_in = ST_MSUM;
            end
         end
         ST_FIRST: begin
            prev_in    = err_ff;
            started_in = 1'b1;
            state_in   = ST_FDONE;
         end
         ST_FDONE: begin
            drive_in = mul_q;
            state_in = ST_OUT;
         end
         ST_MSUM: state_in = ST_INTEG;
         ST_INTEG: begin
            integ_in  = clamp32(sat34(wide_type'(acc_ff) + wide_type'(half_trunc(mul_q))),
                                int_hi_ff, int_lo_ff);
            div_start = 1'b1;
            state_in  = ST_MKI;
         end
         ST_MKI: begin
            total_in = wide_type'(mul_q);
            state_in = ST_ADD1;
         end
         ST_ADD1: begin
            total_in = total_fin;
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) state_in = ST_MKD;
         end
         ST_MKD: state_in = ST_FIN;
         ST_FIN: begin
            drive_in = clamp32(sat34(total_fin), out_hi_ff, out_lo_ff);
            acc_in   = integ_ff;
            prev_in  = err_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         prev_ff    <= '0;
         acc_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         prev_ff    <= prev_in;
         acc_ff     <= acc_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      integ_ff <= integ_in;
      total_ff <= total_in;
      drive_ff <= drive_in;
   end

   ptq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .go     (mul_go),
      .prod_q (mul_q)
   );

   ptq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (diff_e),
      .den   (period_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   ptq_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap (
      .clock (clock),
      .reset (reset),
      .start (wrap_start),
      .diff  (diff),
      .done  (wrap_done),
      .err   (wrap_err)
   );

   // a clear beat answers zero on the next cycle
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_clear_history) |=> (rsp_valid && rsp_drive == '0))
      else $error("clear beat did not answer zero");

   // the first-sample flag never drops outside reset
   a_started_keeps: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped");

   // no request beat taken while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with response pending");

   // the divider finishes only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVW))
      else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the pid trapezoid q13 unit
// Drives directed and random samples through phases of gain / period / limit
// settings and idling mixes, predicts each drive value and checks every beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
   import ptq_pkg::*;
();

   localparam int FB = 13;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic signed [31:0] feedback;
      logic signed [31:0] target;
      logic               clear;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   word_type req_feedback = '0;
   word_type req_target = '0;
   logic req_clear_history = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   word_type rsp_drive;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   pid_trapezoid_q13_unit #(.ANGLE_WRAP(0), .FRAC_BITS(FB)) DUT (.*);

   // controller model state
   logic signed [31:0] kp, ki, kd, out_hi, out_lo, int_hi, int_lo;
   logic [30:0] dt;
   logic signed [31:0] last_err, integ_sum;
   logic seen_first;

   sample_type pending_q[$];
   logic signed [31:0] drive_q[$];
   int send_idle_pct = 0, stall_pct = 0;
   int mismatches = 0, checked = 0, cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // product with floor shift
   function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return sat(p >>> FB);
   endfunction

   // quotient truncated toward zero
   function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                                input logic signed [63:0] b);
      logic signed [63:0] n;
      n = 64'(a) <<< FB;
      if (b == 0) return (n > 0) ? 32'sh7FFF_FFFF : (n < 0) ? 32'sh8000_0000 : 0;
      return sat(n / b);
   endfunction

   function automatic logic signed [31:0] lim(input logic signed [31:0] v,
                                              input logic signed [31:0] hi,
                                              input logic signed [31:0] lo);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic logic signed [31:0] pid_drive(input sample_type s);
      logic signed [31:0] e, sm, hf, ig, dv;
      logic signed [63:0] tot;
      if (s.clear) begin
         last_err = 0;
         integ_sum = 0;
         return 0;
      end
      e = sat(64'(s.target) - 64'(s.feedback));
      if (!seen_first) begin
         seen_first = 1'b1;
         last_err = e;
         return q_mul(kp, e);
      end
      sm = sat(64'(e) + 64'(last_err));
      hf = q_div(q_mul(sm, 32'($signed({1'b0, dt}))), 64'sd2 <<< FB);
      ig = lim(sat(64'(integ_sum) + 64'(hf)), int_hi, int_lo);
      dv = q_div(sat(64'(e) - 64'(last_err)), 64'($signed({1'b0, dt})));
      tot = 64'(q_mul(kp, e)) + 64'(q_mul(ki, ig)) + 64'(q_mul(kd, dv));
      integ_sum = ig;
      last_err = e;
      return lim(sat(tot), out_hi, out_lo);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) drive_q.push_back(pid_drive({req_feedback, req_target,
                                                     req_clear_history}));
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            sample_type s;
            s = pending_q.pop_front();
            req_valid <= 1'b1;
            req_feedback <= s.feedback;
            req_target <= s.target;
            req_clear_history <= s.clear;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and stall
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_q.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected drive beat %0d", rsp_drive);
            end else begin
               logic signed [31:0] want;
               want = drive_q.pop_front();
               checked = checked + 1;
               if (want !== rsp_drive) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("drive beat %0d: expected %0d got %0d", checked, want,
                              rsp_drive);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic signed [31:0] rnd_word();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(2000)) - 1000;
         3: return $signed($urandom_range(200000)) - 100000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_sample(input logic signed [31:0] f, input logic signed [31:0] t,
                             input logic c);
      sample_type s;
      s.feedback = f;
      s.target = t;
      s.clear = c;
      pending_q.push_back(s);
   endtask

   // wait for every queued beat to be answered, then let the unit go idle
   task automatic drain();
      while (pending_q.size() > 0 || req_valid || drive_q.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // one write beat, then csr_valid drops before the next one
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_PROP_GAIN: kp = val;
         REG_INTEG_GAIN: ki = val;
         REG_DERIV_GAIN: kd = val;
         REG_SAMPLE_PERIOD: dt = val[30:0];
         REG_OUT_UPPER: out_hi = val;
         REG_OUT_LOWER: out_lo = val;
         REG_INTEG_UPPER: int_hi = val;
         default: int_lo = val;
      endcase
   endtask

   // one random setting; kind 0 extremes, else mostly moderate values
   task automatic program_all(input int kind);
      logic signed [31:0] a, b;
      if (kind == 0) begin
         csr_write(REG_PROP_GAIN, 32'h7FFF_FFFF);
         csr_write(REG_INTEG_GAIN, 32'h8000_0000);
         csr_write(REG_DERIV_GAIN, 32'h7FFF_FFFF);
         csr_write(REG_SAMPLE_PERIOD, ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'd1);
         csr_write(REG_OUT_UPPER, 32'h7FFF_FFFF);
         csr_write(REG_OUT_LOWER, 32'h8000_0000);
         csr_write(REG_INTEG_UPPER, 32'h7FFF_FFFF);
         csr_write(REG_INTEG_LOWER, 32'h8000_0000);
      end else begin
         csr_write(REG_PROP_GAIN, $signed($urandom_range(65536)) - 32768);
         csr_write(REG_INTEG_GAIN, $signed($urandom_range(16384)) - 8192);
         csr_write(REG_DERIV_GAIN, ($urandom_range(3) == 0) ? $urandom
                                   : $signed($urandom_range(4096)) - 2048);
         csr_write(REG_SAMPLE_PERIOD, ($urandom_range(3) == 0) ? $urandom
                                      : $urandom_range(16384, 1));
         a = $signed($urandom_range(400000)) - 100000;
         b = $signed($urandom_range(400000)) - 300000;
         // sometimes inverted limits
         csr_write(REG_OUT_UPPER, a);
         csr_write(REG_OUT_LOWER, b);
         a = $signed($urandom_range(2000000)) - 500000;
         b = $signed($urandom_range(2000000)) - 1500000;
         csr_write(REG_INTEG_UPPER, a);
         csr_write(REG_INTEG_LOWER, b);
      end
   endtask

   // model reset values
   initial begin
      kp = 0; ki = 0; kd = 0; dt = 31'd8;
      out_hi = 32'sh7FFF_FFFF; out_lo = 32'sh8000_0000;
      int_hi = 32'sh7FFF_FFFF; int_lo = 32'sh8000_0000;
      last_err = 0; integ_sum = 0; seen_first = 1'b0;
   end

   // stimulus sequence
   initial begin
      int p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: reset settings, first sample, then extremes and a clear
      add_sample(32'sd8192, 32'sd16384, 1'b0);
      add_sample(32'sd0, 32'sd8192, 1'b0);
      add_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
      add_sample(32'sd5, 32'sd5, 1'b1);
      drain();
      program_all(0);
      add_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
      add_sample(32'sd0, 32'sd0, 1'b0);
      add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_sample(32'sd100, 32'sd0, 1'b0);
      drain();
      // zero period and inverted limits
      csr_write(REG_SAMPLE_PERIOD, 32'd0);
      csr_write(REG_OUT_UPPER, 32'sd1000);
      csr_write(REG_OUT_LOWER, 32'sd5000);
      csr_write(REG_INTEG_UPPER, -32'sd10);
      csr_write(REG_INTEG_LOWER, 32'sd10);
      add_sample(32'sd0, 32'sd4000, 1'b0);
      add_sample(32'sd0, 32'sd4000, 1'b0);
      add_sample(32'sd4000, 32'sd0, 1'b0);
      add_sample(32'sd0, 32'sd0, 1'b1);
      add_sample(32'sd0, 32'sd0, 1'b0);
      drain();
      // random phases of idling mix and settings
      for (p = 0; p < 16; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 58; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 58; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         program_all((p == 5 || p == 11) ? 0 : 1);
         repeat (118) begin
            add_sample(rnd_word(), rnd_word(), $urandom_range(19) == 0);
            if ($urandom_range(60) == 0) begin
               // hold off until the unit has answered everything
               while (pending_q.size() > 0 || req_valid || drive_q.size() > 0)
                  @(posedge clock);
            end
         end
         drain();
      end
      $display("covered %0d drive beats over 16 setting phases plus directed cases",
               checked);
      $display("including first-sample, clear, zero period and inverted limits");
      if (mismatches == 0) $display("pid_trapezoid_q13_unit: match");
      else $display("pid_trapezoid_q13_unit: mismatch");
      $finish;
   end

   // run limit
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("pid_trapezoid_q13_unit: mismatch");
         $finish;
      end
   end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/ptq_pkg.sv
hw/rtl/ptq_mul.sv
hw/rtl/ptq_div.sv
hw/rtl/ptq_wrap.sv
hw/rtl/pid_trapezoid_q13_unit.sv
sim/tb_top.sv
